>>> hw/rtl/bfs_pkg.sv
// Shared constants, status codes and helpers for the breadth-first path finder.
package bfs_pkg;

    localparam int NODE_COUNT = 64;
    localparam int MAX_DEGREE = 8;

    localparam int FIELD_W    = 6;
    localparam int RANGE_W    = FIELD_W + 1;
    localparam int NODE_IDX_W = $clog2(NODE_COUNT);
    localparam int CNT_W      = $clog2(MAX_DEGREE + 1);
    localparam int LEN_W      = $clog2(NODE_COUNT + 1);
    localparam int TBL_DEPTH  = NODE_COUNT * MAX_DEGREE;
    localparam int TBL_AW     = $clog2(TBL_DEPTH);

    typedef enum logic [1:0] {
        ST_PATH   = 2'd0,
        ST_NOPATH = 2'd1,
        ST_STORED = 2'd2,
        ST_REJECT = 2'd3
    } status_t;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    function automatic logic node_in_range(input logic [FIELD_W-1:0] n);
        return RANGE_W'(n) < RANGE_W'(NODE_COUNT);
    endfunction

    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [NODE_IDX_W-1:0] node,
                                                   input logic [CNT_W-1:0] slot);
        return TBL_AW'(TBL_AW'(node) * TBL_AW'(MAX_DEGREE) + TBL_AW'(slot));
    endfunction

endpackage

>>> hw/rtl/bfs_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
module bfs_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/bfs_shortest_hop_path.sv
// Top level of the breadth-first shortest-hop path finder over a stored directed graph.
// An add-edge item gives one result. A find-path item runs a
// sequencer over one-write, one-read memories: each dequeued node passes the dequeue,
// load and count-read states before its neighbor slots are scanned, each slot scanned
// takes one neighbor table read and one check, and each path node is walked back
// through the parent memory and then emitted from the path stack. The neighbor table
// read port is shared by all slot scans. A new item is taken only once the sequencer is
// back in its idle state; the final result may still wait in the output register then.
module bfs_shortest_hop_path
    import bfs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [FIELD_W-1:0] s_node_a,
    input  logic [FIELD_W-1:0] s_node_b,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [FIELD_W-1:0] m_path_node,
    output logic               m_last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_DO,
        S_FIND_CHK,
        S_NOPATH,
        S_DEQ,
        S_LOAD_CUR,
        S_READ_CNT,
        S_SCAN,
        S_CHECK,
        S_WALK,
        S_PARENT,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [FIELD_W-1:0]      a_reg, a_next;
    logic [FIELD_W-1:0]      b_reg, b_next;
    logic [NODE_IDX_W-1:0]   cur_reg, cur_next;
    logic [NODE_IDX_W-1:0]   node_reg, node_next;
    logic [CNT_W-1:0]        slot_reg, slot_next;
    logic [LEN_W-1:0]        head_reg, head_next;
    logic [LEN_W-1:0]        tail_reg, tail_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [NODE_COUNT-1:0]   visited_reg, visited_next;
    logic [NODE_COUNT-1:0]   cnt_valid_reg, cnt_valid_next;
    logic                    cnt_ok_reg, cnt_ok_next;
    logic                    m_valid_reg, m_valid_next;
    status_t                 m_status_reg, m_status_next;
    logic [FIELD_W-1:0]      m_path_node_reg, m_path_node_next;
    logic                    m_last_reg, m_last_next;

    logic                    out_free;
    logic                    emit;
    logic                    a_ok, b_ok;
    logic [NODE_IDX_W-1:0]   a_idx, b_idx;
    logic [CNT_W-1:0]        cnt_eff;
    logic [LEN_W-1:0]        len_m1;

    logic                    cnt_we, cnt_re;
    logic [NODE_IDX_W-1:0]   cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]        cnt_wdata, cnt_rdata;
    logic                    tbl_we, tbl_re;
    logic [TBL_AW-1:0]       tbl_waddr, tbl_raddr;
    logic [NODE_IDX_W-1:0]   tbl_wdata, tbl_rdata;
    logic                    par_we, par_re;
    logic [NODE_IDX_W-1:0]   par_waddr, par_raddr, par_wdata, par_rdata;
    logic                    q_we, q_re;
    logic [NODE_IDX_W-1:0]   q_waddr, q_raddr, q_wdata, q_rdata;
    logic                    stk_we, stk_re;
    logic [NODE_IDX_W-1:0]   stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    bfs_ram #(.DATA_W(CNT_W), .DEPTH(NODE_COUNT)) u_count_ram (
        .aclk(aclk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
    );

    bfs_ram #(.DATA_W(NODE_IDX_W), .DEPTH(TBL_DEPTH)) u_table_ram (
        .aclk(aclk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
        .re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rdata)
    );

    bfs_ram #(.DATA_W(NODE_IDX_W), .DEPTH(NODE_COUNT)) u_parent_ram (
        .aclk(aclk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
        .re(par_re), .raddr(par_raddr), .rdata(par_rdata)
    );

    bfs_ram #(.DATA_W(NODE_IDX_W), .DEPTH(NODE_COUNT)) u_queue_ram (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
    );

    bfs_ram #(.DATA_W(NODE_IDX_W), .DEPTH(NODE_COUNT)) u_stack_ram (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
    );

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_path_node = m_path_node_reg;
    assign m_last      = m_last_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign a_ok     = node_in_range(a_reg);
    assign b_ok     = node_in_range(b_reg);
    assign a_idx    = a_reg[NODE_IDX_W-1:0];
    assign b_idx    = b_reg[NODE_IDX_W-1:0];
    assign cnt_eff  = cnt_ok_reg ? cnt_rdata : '0;
    assign len_m1   = len_reg - LEN_W'(1);

    always_comb begin
        state_next       = state_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        cur_next         = cur_reg;
        node_next        = node_reg;
        slot_next        = slot_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        len_next         = len_reg;
        visited_next     = visited_reg;
        cnt_valid_next   = cnt_valid_reg;
        cnt_ok_next      = cnt_ok_reg;
        emit             = 1'b0;
        m_status_next    = m_status_reg;
        m_path_node_next = m_path_node_reg;
        m_last_next      = m_last_reg;

        cnt_we    = 1'b0;
        cnt_waddr = a_idx;
        cnt_wdata = CNT_W'(cnt_eff + CNT_W'(1));
        cnt_re    = 1'b0;
        cnt_raddr = cur_reg;
        tbl_we    = 1'b0;
        tbl_waddr = tbl_addr(a_idx, cnt_eff);
        tbl_wdata = b_idx;
        tbl_re    = 1'b0;
        tbl_raddr = tbl_addr(cur_reg, slot_reg);
        par_we    = 1'b0;
        par_waddr = tbl_rdata;
        par_wdata = cur_reg;
        par_re    = 1'b0;
        par_raddr = node_reg;
        q_we      = 1'b0;
        q_waddr   = tail_reg[NODE_IDX_W-1:0];
        q_wdata   = tbl_rdata;
        q_re      = 1'b0;
        q_raddr   = head_reg[NODE_IDX_W-1:0];
        stk_we    = 1'b0;
        stk_waddr = len_reg[NODE_IDX_W-1:0];
        stk_wdata = par_rdata;
        stk_re    = 1'b0;
        stk_raddr = len_m1[NODE_IDX_W-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    a_next     = s_node_a;
                    b_next     = s_node_b;
                    state_next = (s_operation == OP_ADD) ? S_ADD_RD : S_FIND_CHK;
                end
            end
            S_ADD_RD: begin
                cnt_re      = 1'b1;
                cnt_raddr   = a_idx;
                cnt_ok_next = cnt_valid_reg[a_idx];
                state_next  = S_ADD_DO;
            end
            S_ADD_DO: begin
                if (out_free) begin
                    emit             = 1'b1;
                    m_path_node_next = '0;
                    m_last_next      = 1'b1;
                    if (a_ok && b_ok && (cnt_eff < CNT_W'(MAX_DEGREE))) begin
                        m_status_next         = ST_STORED;
                        tbl_we                = 1'b1;
                        cnt_we                = 1'b1;
                        cnt_valid_next[a_idx] = 1'b1;
                    end else begin
                        m_status_next = ST_REJECT;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FIND_CHK: begin
                if (!(a_ok && b_ok)) begin
                    state_next = S_NOPATH;
                end else if (a_reg == b_reg) begin
                    if (out_free) begin
                        emit             = 1'b1;
                        m_status_next    = ST_PATH;
                        m_path_node_next = a_reg;
                        m_last_next      = 1'b1;
                        state_next       = S_IDLE;
                    end
                end else begin
                    visited_next        = '0;
                    visited_next[a_idx] = 1'b1;
                    q_we                = 1'b1;
                    q_waddr             = '0;
                    q_wdata             = a_idx;
                    head_next           = '0;
                    tail_next           = LEN_W'(1);
                    state_next          = S_DEQ;
                end
            end
            S_NOPATH: begin
                if (out_free) begin
                    emit             = 1'b1;
                    m_status_next    = ST_NOPATH;
                    m_path_node_next = '0;
                    m_last_next      = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_DEQ: begin
                if (head_reg == tail_reg) begin
                    state_next = S_NOPATH;
                end else begin
                    q_re       = 1'b1;
                    head_next  = LEN_W'(head_reg + LEN_W'(1));
                    state_next = S_LOAD_CUR;
                end
            end
            S_LOAD_CUR: begin
                cur_next   = q_rdata;
                state_next = S_READ_CNT;
            end
            S_READ_CNT: begin
                cnt_re      = 1'b1;
                cnt_ok_next = cnt_valid_reg[cur_reg];
                slot_next   = '0;
                state_next  = S_SCAN;
            end
            S_SCAN: begin
                if (slot_reg >= cnt_eff) begin
                    state_next = S_DEQ;
                end else begin
                    tbl_re     = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                slot_next  = CNT_W'(slot_reg + CNT_W'(1));
                state_next = S_SCAN;
                if (!visited_reg[tbl_rdata]) begin
                    visited_next[tbl_rdata] = 1'b1;
                    par_we                  = 1'b1;
                    if (tail_reg < LEN_W'(NODE_COUNT)) begin
                        q_we      = 1'b1;
                        tail_next = LEN_W'(tail_reg + LEN_W'(1));
                    end
                    if (tbl_rdata == b_idx) begin
                        stk_we     = 1'b1;
                        stk_waddr  = '0;
                        stk_wdata  = tbl_rdata;
                        len_next   = LEN_W'(1);
                        node_next  = tbl_rdata;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if ((node_reg == a_idx) || (len_reg == LEN_W'(NODE_COUNT))) begin
                    state_next = S_EMIT_RD;
                end else begin
                    par_re     = 1'b1;
                    state_next = S_PARENT;
                end
            end
            S_PARENT: begin
                node_next  = par_rdata;
                stk_we     = 1'b1;
                len_next   = LEN_W'(len_reg + LEN_W'(1));
                state_next = S_WALK;
            end
            S_EMIT_RD: begin
                stk_re     = 1'b1;
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (out_free) begin
                    emit             = 1'b1;
                    m_status_next    = ST_PATH;
                    m_path_node_next = FIELD_W'(stk_rdata);
                    m_last_next      = (len_reg == LEN_W'(1));
                    len_next         = len_m1;
                    state_next       = (len_reg == LEN_W'(1)) ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg           <= a_next;
        b_reg           <= b_next;
        cur_reg         <= cur_next;
        node_reg        <= node_next;
        slot_reg        <= slot_next;
        cnt_ok_reg      <= cnt_ok_next;
        m_status_reg    <= m_status_next;
        m_path_node_reg <= m_path_node_next;
        m_last_reg      <= m_last_next;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            len_reg       <= '0;
            visited_reg   <= '0;
            cnt_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            len_reg       <= len_next;
            visited_reg   <= visited_next;
            cnt_valid_reg <= cnt_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // The search queue never holds more entries than there are nodes.
    a_queue_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg <= tail_reg) && (tail_reg <= LEN_W'(NODE_COUNT)))
        else $error("search queue pointers out of order");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(NODE_COUNT))
        else $error("path length beyond node count");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item taken before the first was finished");

    // Single-result statuses always close the item.
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != ST_PATH)) |-> (m_last_reg && (m_path_node_reg == '0)))
        else $error("non-path result without last or with a node");

    a_idle_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT_OUT && out_free) |=> m_valid_reg)
        else $error("path node transfer lost");

endmodule

>>> tb/bfs_shortest_hop_path_check.sv
// Checker that predicts and compares every result transfer of the path finder.
`timescale 1ns / 1ps

module bfs_shortest_hop_path_check
    import bfs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_operation,
    input  logic [FIELD_W-1:0] s_node_a,
    input  logic [FIELD_W-1:0] s_node_b,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_status,
    input  logic [FIELD_W-1:0] m_path_node,
    input  logic               m_last,
    output int                 fail_count,
    output int                 pending_count
);

    typedef struct packed {
        status_t            status;
        logic [FIELD_W-1:0] node;
        logic               last;
    } hop_result_t;

    logic [FIELD_W-1:0] adj_node [NODE_COUNT][MAX_DEGREE];
    int                 adj_len  [NODE_COUNT];
    hop_result_t        expected_hops [$];
    int                 mismatches = 0;

    function automatic hop_result_t make_hop(status_t st, logic [FIELD_W-1:0] n, logic lst);
        hop_result_t h;
        h.status = st;
        h.node   = n;
        h.last   = lst;
        return h;
    endfunction

    task automatic append_hop(input hop_result_t h);
        expected_hops = {expected_hops, h};
    endtask

    task automatic predict_hops(input logic op, input logic [FIELD_W-1:0] a,
                                input logic [FIELD_W-1:0] b);
        logic               seen      [NODE_COUNT];
        logic [FIELD_W-1:0] came_from [NODE_COUNT];
        logic [FIELD_W-1:0] frontier  [NODE_COUNT];
        logic [FIELD_W-1:0] route [$];
        logic [FIELD_W-1:0] cur;
        logic [FIELD_W-1:0] nb;
        int                 head;
        int                 tail;
        bit                 found;

        if (op == OP_ADD) begin
            if (int'(a) >= NODE_COUNT || int'(b) >= NODE_COUNT || adj_len[a] >= MAX_DEGREE) begin
                append_hop(make_hop(ST_REJECT, '0, 1'b1));
            end else begin
                adj_node[a][adj_len[a]] = b;
                adj_len[a]++;
                append_hop(make_hop(ST_STORED, '0, 1'b1));
            end
            return;
        end
        if (int'(a) >= NODE_COUNT || int'(b) >= NODE_COUNT) begin
            append_hop(make_hop(ST_NOPATH, '0, 1'b1));
            return;
        end
        if (a == b) begin
            append_hop(make_hop(ST_PATH, a, 1'b1));
            return;
        end
        for (int i = 0; i < NODE_COUNT; i++) seen[i] = 1'b0;
        head = 0;
        tail = 0;
        found = 1'b0;
        frontier[tail++] = a;
        seen[a] = 1'b1;
        came_from[a] = a;
        while (head < tail && !found) begin
            cur = frontier[head++];
            for (int s = 0; s < adj_len[cur] && !found; s++) begin
                nb = adj_node[cur][s];
                if (!seen[nb]) begin
                    seen[nb] = 1'b1;
                    came_from[nb] = cur;
                    if (tail < NODE_COUNT) frontier[tail++] = nb;
                    if (nb == b) found = 1'b1;
                end
            end
        end
        if (!found) begin
            append_hop(make_hop(ST_NOPATH, '0, 1'b1));
            return;
        end
        cur = b;
        route.push_front(cur);
        while (cur != a) begin
            cur = came_from[cur];
            route.push_front(cur);
        end
        foreach (route[i]) begin
            append_hop(make_hop(ST_PATH, route[i], i == route.size() - 1));
        end
    endtask

    always @(posedge aclk) begin
        hop_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NODE_COUNT; i++) adj_len[i] = 0;
            expected_hops.delete();
        end else begin
            if (s_valid && s_ready) predict_hops(s_operation, s_node_a, s_node_b);
            if (m_valid && m_ready) begin
                if (expected_hops.size() == 0) begin
                    $error("result transfer with nothing expected: status %0d node %0d last %0d",
                           m_status, m_path_node, m_last);
                    mismatches++;
                end else begin
                    want = expected_hops.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        mismatches++;
                    end
                    if (m_path_node !== want.node) begin
                        $error("path_node: expected %0d, actual %0d", want.node, m_path_node);
                        mismatches++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, m_last);
                        mismatches++;
                    end
                end
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_hops.size();
    end

endmodule

>>> tb/bfs_shortest_hop_path_test.sv
// Testbench top that drives edge and path queries into the path finder and gives the verdict.
`timescale 1ns / 1ps

module bfs_shortest_hop_path_test;
    import bfs_pkg::*;

    localparam int STALL_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 410;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_operation = 1'b0;
    logic [FIELD_W-1:0] s_node_a = '0;
    logic [FIELD_W-1:0] s_node_b = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic [FIELD_W-1:0] m_path_node;
    logic               m_last;

    int fail_count;
    int pending_count;
    int quiet_cycles = 0;
    int ready_hold = 0;
    bit idle_off = 1'b0;

    always #10 aclk = ~aclk;

    bfs_shortest_hop_path dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_node_a    (s_node_a),
        .s_node_b    (s_node_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_path_node (m_path_node),
        .m_last      (m_last)
    );

    bfs_shortest_hop_path_check checker_inst (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_node_a      (s_node_a),
        .s_node_b      (s_node_b),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_path_node   (m_path_node),
        .m_last        (m_last),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15) return $urandom_range(1, 3);
        if (r < 19) return $urandom_range(4, 8);
        return $urandom_range(20, 120);
    endfunction

    task automatic send_item(input logic op, input logic [FIELD_W-1:0] a,
                             input logic [FIELD_W-1:0] b);
        int gap;
        gap = (!idle_off && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_node_a    <= a;
        s_node_b    <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else if (!idle_off && $urandom_range(0, 3) == 0) begin
            m_ready <= 1'b0;
            ready_hold = pick_gap() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty graph: same-node and unreachable finds; then a 0-1-2-63 chain, both ways.
        send_item(OP_FIND, 6'd0, 6'd0);
        send_item(OP_FIND, 6'd63, 6'd63);
        send_item(OP_FIND, 6'd0, 6'd63);
        send_item(OP_ADD, 6'd0, 6'd1);
        send_item(OP_ADD, 6'd1, 6'd2);
        send_item(OP_ADD, 6'd2, 6'd63);
        send_item(OP_FIND, 6'd0, 6'd63);
        send_item(OP_FIND, 6'd63, 6'd0);
        // A self loop and a duplicate edge are stored like any other edge.
        send_item(OP_ADD, 6'd0, 6'd0);
        send_item(OP_ADD, 6'd0, 6'd1);
        send_item(OP_FIND, 6'd0, 6'd2);
        // Fill the list of node 63, then overflow it.
        for (int k = 0; k < MAX_DEGREE + 1; k++) send_item(OP_ADD, 6'd63, FIELD_W'(k));
        send_item(OP_FIND, 6'd63, 6'd2);
        send_item(OP_FIND, 6'd63, 6'd63);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) idle_off = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 9) < 6) begin
                a = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(0, 7))
                                                : FIELD_W'($urandom_range(0, 63));
                b = FIELD_W'($urandom_range(0, 63));
                send_item(OP_ADD, a, b);
            end else begin
                a = FIELD_W'($urandom_range(0, 63));
                b = ($urandom_range(0, 9) == 0) ? a : FIELD_W'($urandom_range(0, 63));
                send_item(OP_FIND, a, b);
            end
        end
        s_valid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
